@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/bgtr_pkg.sv @@
`timescale 1ns / 1ps
package bgtr_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_ROW = 2'd0,
    CMD_LOAD_ADV = 2'd1,
    CMD_DRAW     = 2'd2,
    CMD_RESTART  = 2'd3
  } command_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  HIGH_CODE    = 8'h80;
  localparam logic [7:0]  LINE_STEP    = 8'd20;
  localparam logic [12:0] PITCH_RESET  = 13'd960;

  // Controller to datapath
  typedef struct packed {
    logic load_row;
    logic load_adv;
    logic restart;
    logic newline;
    logic draw_start;
    logic base_load;
    logic span_next;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_span;
  } ctrl_status_t;

endpackage

@@ hw/rtl/bgtr_ram.sv @@
`timescale 1ns / 1ps
module bgtr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bgtr_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bgtr_ctrl import bgtr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic [7:0]   text_char_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output ctrl_cmd_t    cmd_o,
  input  ctrl_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SPAN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_stall_q;
  logic   in_acc;
  logic   out_acc;
  logic   is_draw;
  logic   is_newline;

  assign in_acc     = in_valid_i && !in_stall_q;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign is_draw    = command_i == CMD_DRAW;
  assign is_newline = text_char_i == NEWLINE_CODE;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_row   = in_acc && (command_i == CMD_LOAD_ROW);
    cmd_o.load_adv   = in_acc && (command_i == CMD_LOAD_ADV);
    cmd_o.restart    = in_acc && (command_i == CMD_RESTART);
    cmd_o.newline    = in_acc && is_draw && is_newline;
    cmd_o.draw_start = in_acc && is_draw && !is_newline;
    cmd_o.base_load  = state_q == ST_SETUP;
    cmd_o.span_next  = out_acc;
    cmd_o.finish     = out_acc && status_i.last_span;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      in_stall_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_draw && !is_newline) begin
            state_q    <= ST_SETUP;
            in_stall_q <= 1'b1;
          end
        end
        ST_SETUP: begin
          state_q     <= ST_SPAN;
          out_valid_q <= 1'b1;
        end
        ST_SPAN: begin
          // drop back to idle once the final span is taken
          if (out_acc && status_i.last_span) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
          in_stall_q  <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  `ASSERT_ON(a_no_input_while_spans, !(out_valid_q && in_valid_i && !in_stall_q), "input taken during spans")
  `ASSERT_ON(a_cmd_onehot, $onehot0({cmd_o.load_row, cmd_o.load_adv, cmd_o.restart, cmd_o.newline, cmd_o.draw_start, cmd_o.base_load, cmd_o.span_next}), "overlapping commands")
  `ASSERT_NEXT(a_draw_then_base, cmd_o.draw_start, cmd_o.base_load, "base not loaded after draw")
  `ASSERT_NEXT(a_drain_after_last, out_acc && status_i.last_span, !out_valid_q, "span after last row")

endmodule

@@ hw/rtl/bgtr_datapath.sv @@
`timescale 1ns / 1ps
module bgtr_datapath import bgtr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned GLYPH_ROWS  = 16,
  parameter int unsigned GLYPH_COLS  = 8,
  parameter int unsigned MAX_ZOOM    = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_status_t          status_o,
  input  logic [6:0]            glyph_index_i,
  input  logic [3:0]            row_index_i,
  input  logic [7:0]            row_bits_i,
  input  logic [3:0]            advance_width_i,
  input  logic [7:0]            text_char_i,
  output logic [23:0]           word_address_o,
  output logic [31:0]           pixel_mask_o,
  output logic [31:0]           pixel_color_o,
  output logic                  last_row_o
);

  localparam int unsigned GW    = $clog2(GLYPH_COUNT);
  localparam int unsigned DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(GLYPH_ROWS << MAX_ZOOM);
  localparam int unsigned GA_W  = 14;

  logic [11:0] origin_x_q, origin_y_q;
  logic [1:0]  zoom_q, zoom_eff;
  logic [12:0] pitch_q;
  logic [31:0] color_q;

  logic [12:0] cursor_x_q, cursor_y_q;
  logic [RW-1:0] row_q, row_d, frow, last_idx;
  logic [GW-1:0] glyph_q, glyph_code, glyph_sel;
  logic [23:0] addr_q;
  logic [25:0] prod;

  logic [8:0] code_w, gidx_w;
  logic       code_ok, gidx_ok, ridx_ok;
  logic [GA_W-1:0] rd_wide, wr_wide;
  logic [8:0] spans_m1;
  logic [7:0] glyph_rdata;
  logic [3:0] adv_rdata;
  logic [7:0] adv_step, line_step;

  function automatic logic [31:0] expand_row(input logic [7:0] bits, input logic [1:0] z);
    logic [31:0] m;
    logic [7:0]  cols;
    logic [4:0]  col;
    m    = '0;
    cols = 8'(GLYPH_COLS) << z;
    for (int bx = 0; bx < 32; bx++) begin
      col = 5'(bx) >> z;
      if ((8'(bx) < cols) && (col < 5'd8) && bits[col[2:0]]) begin
        m[bx] = 1'b1;
      end
    end
    return m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      zoom_q     <= '0;
      pitch_q    <= PITCH_RESET;
      color_q    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:   origin_x_q <= cfg_data_i[11:0];
        REG_ORIGIN_Y:   origin_y_q <= cfg_data_i[11:0];
        REG_ZOOM_SHIFT: zoom_q     <= cfg_data_i[1:0];
        REG_LINE_PITCH: pitch_q    <= cfg_data_i[12:0];
        REG_TEXT_COLOR: color_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign zoom_eff = (zoom_q > 2'(MAX_ZOOM)) ? 2'(MAX_ZOOM) : zoom_q;

  // high codes and codes at or above GLYPH_COUNT fall back to glyph 0
  assign code_w     = {1'b0, text_char_i};
  assign code_ok    = (code_w < {1'b0, HIGH_CODE}) && (code_w < 9'(GLYPH_COUNT));
  assign glyph_code = code_ok ? code_w[GW-1:0] : '0;
  assign glyph_sel  = cmd_i.draw_start ? glyph_code : glyph_q;

  assign gidx_w  = {2'b00, glyph_index_i};
  assign gidx_ok = gidx_w < 9'(GLYPH_COUNT);
  assign ridx_ok = {2'b00, row_index_i} < 6'(GLYPH_ROWS);

  assign spans_m1 = (9'(GLYPH_ROWS) << zoom_eff) - 9'd1;
  assign last_idx = spans_m1[RW-1:0];
  assign status_o.last_span = row_q == last_idx;

  always_comb begin
    row_d = row_q;
    if (cmd_i.draw_start || cmd_i.finish) begin
      row_d = '0;
    end else if (cmd_i.span_next) begin
      row_d = row_q + 1'b1;
    end
  end

  // read the row that will be current after this edge
  assign frow    = row_d >> zoom_eff;
  assign rd_wide = GA_W'(glyph_sel) * GA_W'(GLYPH_ROWS) + GA_W'(frow);
  assign wr_wide = GA_W'(gidx_w[GW-1:0]) * GA_W'(GLYPH_ROWS) + GA_W'(row_index_i);

  bgtr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_row && gidx_ok && ridx_ok),
    .waddr_i (wr_wide[AW-1:0]),
    .wdata_i (row_bits_i),
    .raddr_i (rd_wide[AW-1:0]),
    .rdata_o (glyph_rdata)
  );

  bgtr_ram #(
    .WIDTH (4),
    .DEPTH (GLYPH_COUNT)
  ) u_adv_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_adv && gidx_ok),
    .waddr_i (gidx_w[GW-1:0]),
    .wdata_i (advance_width_i),
    .raddr_i (glyph_sel),
    .rdata_o (adv_rdata)
  );

  assign adv_step  = 8'({1'b0, adv_rdata} + 5'd1) << zoom_eff;
  assign line_step = LINE_STEP << zoom_eff;
  assign prod      = cursor_y_q * pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      row_q      <= '0;
    end else begin
      row_q <= row_d;
      if (cmd_i.restart) begin
        cursor_x_q <= {1'b0, origin_x_q};
        cursor_y_q <= {1'b0, origin_y_q};
      end else if (cmd_i.newline) begin
        cursor_x_q <= {1'b0, origin_x_q};
        cursor_y_q <= cursor_y_q + 13'(line_step);
      end else if (cmd_i.finish) begin
        cursor_x_q <= cursor_x_q + 13'(adv_step);
      end
    end
  end

  // load the base address on setup, then step it by one pitch per row
  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_sel;
    if (cmd_i.base_load) begin
      addr_q <= prod[23:0] + {11'b0, cursor_x_q};
    end else if (cmd_i.span_next) begin
      addr_q <= addr_q + {11'b0, pitch_q};
    end
  end

  assign word_address_o = addr_q;
  assign pixel_mask_o   = expand_row(glyph_rdata, zoom_eff);
  assign pixel_color_o  = color_q;
  assign last_row_o     = status_o.last_span;

endmodule

@@ hw/rtl/bitmap_text_glyph_renderer_core.sv @@
`timescale 1ns / 1ps
// Bitmap text renderer: loads 8-pixel glyph rows and advance widths into two
// on-chip RAMs, then expands each drawn character into framebuffer row spans
// (address, 32-bit pixel mask with bit 0 leftmost, color), GLYPH_ROWS << zoom
// spans per character with the last one flagged. Load, restart and newline
// items produce nothing. A draw item is accepted, then the setup state forms
// the base address (cursor_y * line_pitch + cursor_x through a single
// multiplier), then spans follow at one per cycle while the output is not
// stalled. Span rate is set by the glyph RAM read port, which fetches one row
// per cycle. Input is stalled from draw acceptance until the final span is
// taken. The glyph RAMs are not cleared by reset; load every glyph before
// drawing it. The user must write configuration only while idle; the block
// does not enforce this.
module bitmap_text_glyph_renderer_core import bgtr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned GLYPH_ROWS  = 16,
  parameter int unsigned GLYPH_COLS  = 8,
  parameter int unsigned MAX_ZOOM    = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [6:0]            glyph_index_i,
  input  logic [3:0]            row_index_i,
  input  logic [7:0]            row_bits_i,
  input  logic [3:0]            advance_width_i,
  input  logic [7:0]            text_char_i,
  // span items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [23:0]           word_address_o,
  output logic [31:0]           pixel_mask_o,
  output logic [31:0]           pixel_color_o,
  output logic                  last_row_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer: decode items, run setup and the span loop
  bgtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .text_char_i (text_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // registers, cursor, glyph RAMs, address stepping and mask expansion
  bgtr_datapath #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COLS  (GLYPH_COLS),
    .MAX_ZOOM    (MAX_ZOOM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .glyph_index_i   (glyph_index_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .advance_width_i (advance_width_i),
    .text_char_i     (text_char_i),
    .word_address_o  (word_address_o),
    .pixel_mask_o    (pixel_mask_o),
    .pixel_color_o   (pixel_color_o),
    .last_row_o      (last_row_o)
  );

endmodule

@@ tb/sv/span_checker.sv @@
`timescale 1ns / 1ps
module span_checker import bgtr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            command_i,
  input  logic [6:0]            glyph_index_i,
  input  logic [3:0]            row_index_i,
  input  logic [7:0]            row_bits_i,
  input  logic [3:0]            advance_width_i,
  input  logic [7:0]            text_char_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [23:0]           word_address_i,
  input  logic [31:0]           pixel_mask_i,
  input  logic [31:0]           pixel_color_i,
  input  logic                  last_row_i,
  output int                    spans_pending_o,
  output int                    mismatches_o
);

  localparam int FONT_ROWS = 16;
  localparam int FONT_COLS = 8;
  localparam int ZOOM_CAP  = 2;

  typedef struct packed {
    logic [23:0] addr;
    logic [31:0] mask;
    logic [31:0] color;
    logic        last;
  } span_t;

  span_t       expected_spans[$];
  span_t       want;
  logic [11:0] org_x;
  logic [11:0] org_y;
  logic [1:0]  zoom_reg;
  logic [12:0] pitch;
  logic [31:0] color;
  logic [12:0] pen_x;
  logic [12:0] pen_y;
  logic [7:0]  font_rows [0:2047];
  logic [3:0]  font_adv [0:127];

  function automatic logic [31:0] scale_row(logic [7:0] bits, int z);
    logic [31:0] m;
    m = '0;
    for (int bx = 0; bx < (FONT_COLS << z) && bx < 32; bx++) begin
      if (bits[bx >> z]) m[bx] = 1'b1;
    end
    return m;
  endfunction

  task automatic report(string msg);
    $display("%0t span check: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic predict_spans();
    int          z;
    int          g;
    int          spans;
    logic [31:0] line_addr;
    span_t       s;
    z = (zoom_reg > ZOOM_CAP) ? ZOOM_CAP : int'(zoom_reg);
    case (command_i)
      CMD_LOAD_ROW: font_rows[{glyph_index_i, row_index_i}] = row_bits_i;
      CMD_LOAD_ADV: font_adv[glyph_index_i] = advance_width_i;
      CMD_RESTART: begin
        pen_x = 13'(org_x);
        pen_y = 13'(org_y);
      end
      default: begin
        if (text_char_i == NEWLINE_CODE) begin
          pen_x = 13'(org_x);
          pen_y = pen_y + 13'(int'(LINE_STEP) << z);
        end else begin
          // high codes fall back to glyph 0
          g = (text_char_i < HIGH_CODE) ? int'(text_char_i) : 0;
          spans = FONT_ROWS << z;
          for (int r = 0; r < spans; r++) begin
            line_addr = (32'(pen_y) + 32'(r)) * 32'(pitch) + 32'(pen_x);
            s.addr  = line_addr[23:0];
            s.mask  = scale_row(font_rows[g * FONT_ROWS + (r >> z)], z);
            s.color = color;
            s.last  = (r == spans - 1);
            expected_spans.push_back(s);
          end
          pen_x = pen_x + 13'((int'(font_adv[g]) + 1) << z);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x = '0;
      org_y = '0;
      zoom_reg = '0;
      pitch = PITCH_RESET;
      color = '1;
      pen_x = '0;
      pen_y = '0;
      expected_spans.delete();
      spans_pending_o = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:   org_x = cfg_data_i[11:0];
          REG_ORIGIN_Y:   org_y = cfg_data_i[11:0];
          REG_ZOOM_SHIFT: zoom_reg = cfg_data_i[1:0];
          REG_LINE_PITCH: pitch = cfg_data_i[12:0];
          REG_TEXT_COLOR: color = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_spans();
      if (out_valid_i && !out_stall_i) begin
        if (expected_spans.size() == 0) begin
          report($sformatf("unexpected span at address %h", word_address_i));
        end else begin
          want = expected_spans.pop_front();
          if (word_address_i !== want.addr)
            report($sformatf("word_address %h, predicted %h", word_address_i, want.addr));
          if (pixel_mask_i !== want.mask)
            report($sformatf("pixel_mask %h, predicted %h", pixel_mask_i, want.mask));
          if (pixel_color_i !== want.color)
            report($sformatf("pixel_color %h, predicted %h", pixel_color_i, want.color));
          if (last_row_i !== want.last)
            report($sformatf("last_row %b, predicted %b", last_row_i, want.last));
        end
      end
      spans_pending_o = expected_spans.size();
    end
  end

endmodule

@@ tb/sv/bitmap_text_glyph_renderer_core_test.sv @@
`timescale 1ns / 1ps
module bitmap_text_glyph_renderer_core_test;
  import bgtr_pkg::*;

  // Longest quiet stretch of a correct run is the receiver hold-off plus the
  // drain wait; the limit leaves several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_PCT       = 23;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            command;
  logic [6:0]            glyph_index;
  logic [3:0]            row_index;
  logic [7:0]            row_bits;
  logic [3:0]            advance_width;
  logic [7:0]            text_char;
  logic                  out_valid;
  logic                  out_stall;
  logic [23:0]           word_address;
  logic [31:0]           pixel_mask;
  logic [31:0]           pixel_color;
  logic                  last_row;
  int                    spans_pending;
  int                    mismatches;

  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit hold_req = 1'b0;
  bit steady = 1'b0;

  // Glyphs whose rows and width are all loaded; only these are ever drawn.
  bit glyph_ready [0:127];
  int ready_glyphs[$];

  bitmap_text_glyph_renderer_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .glyph_index_i   (glyph_index),
    .row_index_i     (row_index),
    .row_bits_i      (row_bits),
    .advance_width_i (advance_width),
    .text_char_i     (text_char),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .word_address_o  (word_address),
    .pixel_mask_o    (pixel_mask),
    .pixel_color_o   (pixel_color),
    .last_row_o      (last_row)
  );

  span_checker span_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .glyph_index_i   (glyph_index),
    .row_index_i     (row_index),
    .row_bits_i      (row_bits),
    .advance_width_i (advance_width),
    .text_char_i     (text_char),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .word_address_i  (word_address),
    .pixel_mask_i    (pixel_mask),
    .pixel_color_i   (pixel_color),
    .last_row_i      (last_row),
    .spans_pending_o (spans_pending),
    .mismatches_o    (mismatches)
  );

  always #1 clk = ~clk;

  // Count cycles in which no item moves on either channel and no register is
  // written; give up when the count hits the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("bitmap_text_glyph_renderer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver side: random stalls, none in steady phases, and one long hold-off
  // on request so the block backs up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one item: idle at random first unless steady, then hold the payload until taken.
  task automatic send_item(command_e cmd, logic [6:0] gi, logic [3:0] ri, logic [7:0] rb,
                           logic [3:0] aw, logic [7:0] tc);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= cmd;
    glyph_index <= gi;
    row_index <= ri;
    row_bits <= rb;
    advance_width <= aw;
    text_char <= tc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_row(int g, int r, logic [7:0] bits);
    send_item(CMD_LOAD_ROW, 7'(g), 4'(r), bits, 4'($urandom), 8'($urandom));
  endtask

  task automatic load_width(int g, int w);
    send_item(CMD_LOAD_ADV, 7'(g), 4'($urandom), 8'($urandom), 4'(w), 8'($urandom));
  endtask

  task automatic draw(logic [7:0] ch);
    send_item(CMD_DRAW, 7'($urandom), 4'($urandom), 8'($urandom), 4'($urandom), ch);
  endtask

  task automatic restart_cursor();
    send_item(CMD_RESTART, 7'($urandom), 4'($urandom), 8'($urandom), 4'($urandom),
              8'($urandom));
  endtask

  task automatic mark_ready(int g);
    if (!glyph_ready[g]) begin
      glyph_ready[g] = 1'b1;
      ready_glyphs.push_back(g);
    end
  endtask

  // Load a full glyph: all rows, then the width. Solid and blank rows are
  // favored so masks hit both extremes often.
  task automatic load_glyph(int g);
    logic [7:0] bits;
    for (int r = 0; r < 16; r++) begin
      case ($urandom_range(5))
        0:       bits = 8'h00;
        1:       bits = 8'hFF;
        default: bits = 8'($urandom);
      endcase
      load_row(g, r, bits);
    end
    load_width(g, $urandom_range(15));
    mark_ready(g);
  endtask

  // Choose a code that only ever reads loaded glyph memory.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 8 || ready_glyphs.size() == 0) return NEWLINE_CODE;
    if (r < 18 && glyph_ready[0]) return 8'(int'(HIGH_CODE) + $urandom_range(127));
    return 8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
  endfunction

  // Mostly draws of loaded glyphs, with whole-glyph loads, stray row and
  // width reloads, and restarts mixed in.
  task automatic run_mix(int n);
    int sent;
    int r;
    int g;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 8 || ready_glyphs.size() < 2) begin
        g = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 127 : 0) : $urandom_range(127);
        load_glyph(g);
        sent += 17;
      end else if (r < 14) begin
        if ($urandom_range(1))
          load_row($urandom_range(127), $urandom_range(15), 8'($urandom));
        else
          load_width($urandom_range(127), $urandom_range(15));
        sent++;
      end else if (r < 20) begin
        restart_cursor();
        sent++;
      end else begin
        draw(pick_char());
        sent++;
      end
    end
  endtask

  // Drop valid, wait out every predicted span, then let the block finish any
  // newline or restart that produced nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (spans_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [11:0] ox, logic [11:0] oy, logic [1:0] zs,
                            logic [12:0] lp, logic [31:0] tc);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= 32'(ox);
    @(negedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data <= 32'(oy);
    @(negedge clk);
    cfg_index <= REG_ZOOM_SHIFT;
    cfg_data <= 32'(zs);
    @(negedge clk);
    cfg_index <= REG_LINE_PITCH;
    cfg_data <= 32'(lp);
    @(negedge clk);
    cfg_index <= REG_TEXT_COLOR;
    cfg_data <= tc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_RESTART;
    glyph_index = '0;
    row_index = '0;
    row_bits = '0;
    advance_width = '0;
    text_char = '0;
    out_stall = 1'b0;
    for (int g = 0; g < 128; g++) glyph_ready[g] = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: glyph 0 with blank, solid, leftmost
    // only and rightmost only rows, then high codes, newline and restart.
    for (int r = 0; r < 16; r++) begin
      case (r)
        0:       load_row(0, r, 8'h00);
        1:       load_row(0, r, 8'hFF);
        2:       load_row(0, r, 8'h01);
        3:       load_row(0, r, 8'h80);
        default: load_row(0, r, 8'($urandom));
      endcase
    end
    load_width(0, 15);
    mark_ready(0);
    draw(8'd0);
    draw(8'd255);
    draw(HIGH_CODE);
    draw(NEWLINE_CODE);
    restart_cursor();
    load_width(0, 0);
    draw(8'd0);

    // Extremes: far origin, zoom past its cap, widest pitch, black ink.
    // Run the cursor down and across until both coordinates wrap.
    settle();
    write_regs(12'hFFF, 12'hFFF, 2'd3, 13'h1FFF, 32'h0000_0000);
    restart_cursor();
    repeat (55) draw(NEWLINE_CODE);
    load_width(0, 15);
    repeat (70) draw(8'(int'(HIGH_CODE) + $urandom_range(127)));
    run_mix(20);

    // Smallest nonzero pitch at zoom 1; partway through, back the output up.
    settle();
    write_regs(12'h000, 12'h000, 2'd1, 13'd1, 32'hFFFF_FFFF);
    run_mix(20);
    hold_req = 1'b1;
    run_mix(30);

    // Zero pitch at full zoom with no idling on either side.
    settle();
    write_regs(12'($urandom), 12'($urandom), 2'd2, 13'd0, $urandom);
    steady = 1'b1;
    run_mix(40);
    settle();
    steady = 1'b0;

    write_regs(12'($urandom), 12'($urandom), 2'd0, 13'd4096, $urandom);
    run_mix(40);

    repeat (3) begin
      settle();
      write_regs(12'($urandom), 12'($urandom), 2'($urandom_range(3)),
                 13'($urandom_range(4096, 1)), $urandom);
      run_mix(25);
    end

    settle();
    if (mismatches == 0) begin
      $display("bitmap_text_glyph_renderer_core verification clean");
    end else begin
      $display("bitmap_text_glyph_renderer_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bgtr_pkg.sv
hw/rtl/bgtr_ram.sv
hw/rtl/bgtr_ctrl.sv
hw/rtl/bgtr_datapath.sv
hw/rtl/bitmap_text_glyph_renderer_core.sv
tb/sv/span_checker.sv
tb/sv/bitmap_text_glyph_renderer_core_test.sv
